>>> rtl/cross_stencil_tile_average_macros.svh
// Assertion helpers used by the top-level RTL module.
`ifndef CROSS_STENCIL_TILE_AVERAGE_MACROS_SVH
`define CROSS_STENCIL_TILE_AVERAGE_MACROS_SVH

// same-cycle implication
`define CSTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/csta_pkg.sv
package csta_pkg;

    localparam int POS_W     = 6;
    localparam int DIM_W     = 7;
    localparam int DATA_W    = 41;
    localparam int CNT_W     = 4;
    localparam int SUM_W     = 45;
    localparam int DIG_W     = 4;
    localparam int DIV_STEPS = 12;
    localparam int STEP_W    = 4;
    localparam int REM_W     = 2 * DIG_W;
    localparam int CW        = 9;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 7;

    typedef enum logic [1:0] {
        CMD_WR_TILE = 2'd0,
        CMD_WR_HALO = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_COMMIT  = 2'd3
    } t_cmd;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_LEFT   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    localparam logic [IDX_W-1:0] REG_RADIUS     = 3'd0;
    localparam logic [IDX_W-1:0] REG_TILE_DIM   = 3'd1;
    localparam logic [IDX_W-1:0] REG_HAS_TOP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_HAS_BOTTOM = 3'd3;
    localparam logic [IDX_W-1:0] REG_HAS_LEFT   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HAS_RIGHT  = 3'd5;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/csta_ram.sv
module csta_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/csta_div.sv
module csta_div
    import csta_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [SUM_W-1:0] i_dividend,
    output t_div_rsp         o_rsp
);

    localparam int DVD_W = DIV_STEPS * DIG_W;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_steps;
    logic [DVD_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;

    logic [CNT_W-1:0]  n_rem;
    logic [DIG_W-1:0]  n_digit;

    // radix-16 digit: compare partial remainder against divisor multiples
    always_comb begin
        logic [REM_W-1:0] p;
        logic [REM_W-1:0] prod;
        p       = {r_rem, r_dvd[DVD_W-1 -: DIG_W]};
        n_digit = '0;
        n_rem   = CNT_W'(p);
        for (int j = 1; j < (1 << DIG_W); j++) begin
            prod = REM_W'({{(REM_W-CNT_W){1'b0}}, r_dvs} * REM_W'(j));
            if (p >= prod) begin
                n_digit = DIG_W'(j);
                n_rem   = CNT_W'(p - prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_steps == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_steps == STEP_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
        if (i_req.start) begin
            r_dvd   <= DVD_W'(i_dividend);
            r_dvs   <= i_req.divisor;
            r_rem   <= '0;
            r_quo   <= '0;
            r_steps <= STEP_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_dvd   <= {r_dvd[DVD_W-DIG_W-1:0], {DIG_W{1'b0}}};
            r_rem   <= n_rem;
            r_quo   <= {r_quo[SUM_W-DIG_W-1:0], n_digit};
            r_steps <= r_steps - STEP_W'(1);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> rtl/cross_stencil_tile_average.sv
// Channel   Handshake                        Payload
// command   start / busy                     i_cmd i_side i_depth i_row i_col i_value
// config    i_cfg_valid / o_cfg_ready        i_cfg_index i_cfg_data
// result    o_result_valid (one-cycle word)  o_out_row o_out_col o_average
//
// Tile write, halo write, commit and out-of-tile computes do not raise busy.
// A compute keeps busy high through one tile or halo memory read
// per stencil point, then a 12-digit radix-16 divide; the word appears the cycle after.
// i_rst_n is synchronous; it clears bank select, config and control, not the memories.
// The result word cannot be stalled; o_cfg_ready is always high.
`include "cross_stencil_tile_average_macros.svh"

module cross_stencil_tile_average
    import csta_pkg::*;
#(
    parameter int TILE_MAX   = 64,
    parameter int MAX_RADIUS = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [1:0]        i_side,
    input  logic              i_depth,
    input  logic [POS_W-1:0]  i_row,
    input  logic [POS_W-1:0]  i_col,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_result_valid,
    output logic [POS_W-1:0]  o_out_row,
    output logic [POS_W-1:0]  o_out_col,
    output logic [DATA_W-1:0] o_average
);

    localparam int TDEPTH = 2 * TILE_MAX * TILE_MAX;
    localparam int HDEPTH = 4 * MAX_RADIUS * TILE_MAX;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int HAW    = $clog2(HDEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER,
        S_DRAIN,
        S_DIV,
        S_WAIT
    } t_state;

    typedef enum logic [1:0] {
        DIR_BOTTOM,
        DIR_TOP,
        DIR_RIGHT,
        DIR_LEFT
    } t_dir;

    function automatic logic [TAW-1:0] tile_addr(input logic bank, input logic [CW-1:0] row,
                                                 input logic [CW-1:0] col);
        return TAW'((TAW'(bank) * TAW'(TILE_MAX) + TAW'(row)) * TAW'(TILE_MAX) + TAW'(col));
    endfunction

    function automatic logic [HAW-1:0] halo_addr(input logic [1:0] side,
                                                 input logic [CW-1:0] t,
                                                 input logic [CW-1:0] pos);
        return HAW'((HAW'(side) * HAW'(MAX_RADIUS) + HAW'(t)) * HAW'(TILE_MAX) + HAW'(pos));
    endfunction

    t_state            r_state, n_state;
    t_dir              r_dir, n_dir;
    logic [1:0]        r_k, n_k;
    logic              r_bank;
    logic [1:0]        r_radius;
    logic [DIM_W-1:0]  r_tile_dim;
    logic              r_has_top, r_has_bottom, r_has_left, r_has_right;
    logic              r_pend, n_pend;
    logic              r_pend_halo, n_pend_halo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [POS_W-1:0]  r_row, r_col;
    logic              r_valid;
    logic [POS_W-1:0]  r_out_row, r_out_col;
    logic [DATA_W-1:0] r_avg;

    logic [CW-1:0]     eff_n;
    logic [1:0]        eff_rad;
    logic              accept;
    logic              in_range;
    t_cmd              cmd;

    logic              in_tile, halo_en;
    logic [CW-1:0]     trow, tcol, ht, hpos;
    logic [1:0]        hside;
    logic              use_tile, use_halo;

    logic              t_we, h_we;
    logic [TAW-1:0]    t_waddr, t_raddr;
    logic [HAW-1:0]    h_waddr, h_raddr;
    logic [DATA_W-1:0] t_wdata, t_rdata, h_rdata;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign eff_n   = (r_tile_dim == '0) ? CW'(1) :
                     (CW'(r_tile_dim) > CW'(TILE_MAX)) ? CW'(TILE_MAX) : CW'(r_tile_dim);
    assign eff_rad = (r_radius == 2'd0) ? 2'd1 :
                     (r_radius > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : r_radius;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign cmd         = t_cmd'(i_cmd);
    assign in_range    = (CW'(i_row) < eff_n) && (CW'(i_col) < eff_n);
    assign o_cfg_ready = 1'b1;

    // current stencil point: inside the tile, else from the halo line if that side is enabled
    always_comb begin
        logic [CW-1:0] r8, c8, k8;
        r8      = CW'(r_row);
        c8      = CW'(r_col);
        k8      = CW'(r_k);
        trow    = r8;
        tcol    = c8;
        hpos    = c8;
        in_tile = 1'b0;
        halo_en = 1'b0;
        hside   = SIDE_TOP;
        ht      = '0;
        case (r_dir)
            DIR_BOTTOM: begin
                trow    = r8 + CW'(1) + k8;
                in_tile = trow < eff_n;
                ht      = trow - eff_n;
                hside   = SIDE_BOTTOM;
                halo_en = r_has_bottom;
            end
            DIR_TOP: begin
                trow    = r8 - CW'(1) - k8;
                in_tile = k8 < r8;
                ht      = k8 - r8;
                hside   = SIDE_TOP;
                halo_en = r_has_top;
            end
            DIR_RIGHT: begin
                tcol    = c8 + CW'(1) + k8;
                in_tile = tcol < eff_n;
                ht      = tcol - eff_n;
                hpos    = r8;
                hside   = SIDE_RIGHT;
                halo_en = r_has_right;
            end
            DIR_LEFT: begin
                tcol    = c8 - CW'(1) - k8;
                in_tile = k8 < c8;
                ht      = k8 - c8;
                hpos    = r8;
                hside   = SIDE_LEFT;
                halo_en = r_has_left;
            end
            default: begin
                in_tile = 1'b0;
            end
        endcase
        use_tile = in_tile;
        use_halo = !in_tile && halo_en;
    end

    always_comb begin
        t_raddr = (r_state == S_IDLE) ? tile_addr(r_bank, CW'(i_row), CW'(i_col))
                                      : tile_addr(r_bank, trow, tcol);
        h_raddr = halo_addr(hside, ht, hpos);
        h_we    = accept && (cmd == CMD_WR_HALO) && (CW'(i_col) < eff_n)
                  && (CW'(i_depth) < CW'(MAX_RADIUS));
        h_waddr = halo_addr(i_side, CW'(i_depth), CW'(i_col));
        if (r_state == S_WAIT) begin
            t_we    = div_rsp.done;
            t_waddr = tile_addr(!r_bank, CW'(r_row), CW'(r_col));
            t_wdata = div_rsp.quotient[DATA_W-1:0];
        end else begin
            t_we    = accept && (cmd == CMD_WR_TILE) && in_range;
            t_waddr = tile_addr(r_bank, CW'(i_row), CW'(i_col));
            t_wdata = i_value;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_pend_halo = 1'b0;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        if (r_pend) begin
            n_sum = r_sum + SUM_W'(r_pend_halo ? h_rdata : t_rdata);
        end
        case (r_state)
            S_IDLE: begin
                if (accept && (cmd == CMD_COMPUTE) && in_range) begin
                    n_state = S_GATHER;
                    n_dir   = DIR_BOTTOM;
                    n_k     = 2'd0;
                    n_pend  = 1'b1;
                    n_cnt   = CNT_W'(1);
                    n_sum   = '0;
                end
            end
            S_GATHER: begin
                n_pend      = use_tile || use_halo;
                n_pend_halo = use_halo;
                n_cnt       = r_cnt + CNT_W'(use_tile || use_halo);
                if (r_k == eff_rad - 2'd1) begin
                    n_k = 2'd0;
                    if (r_dir == DIR_LEFT) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_dir = t_dir'(r_dir + 2'd1);
                    end
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bank       <= 1'b0;
            r_pend       <= 1'b0;
            r_valid      <= 1'b0;
            r_radius     <= 2'd1;
            r_tile_dim   <= DIM_W'(64);
            r_has_top    <= 1'b0;
            r_has_bottom <= 1'b0;
            r_has_left   <= 1'b0;
            r_has_right  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_valid <= (r_state == S_WAIT) && div_rsp.done;
            if (accept && (cmd == CMD_COMMIT)) begin
                r_bank <= !r_bank;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RADIUS:     r_radius     <= i_cfg_data[1:0];
                    REG_TILE_DIM:   r_tile_dim   <= i_cfg_data[DIM_W-1:0];
                    REG_HAS_TOP:    r_has_top    <= i_cfg_data[0];
                    REG_HAS_BOTTOM: r_has_bottom <= i_cfg_data[0];
                    REG_HAS_LEFT:   r_has_left   <= i_cfg_data[0];
                    REG_HAS_RIGHT:  r_has_right  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        r_dir       <= n_dir;
        r_k         <= n_k;
        r_pend_halo <= n_pend_halo;
        r_cnt       <= n_cnt;
        r_sum       <= n_sum;
        if (accept) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if ((r_state == S_WAIT) && div_rsp.done) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_avg     <= div_rsp.quotient[DATA_W-1:0];
        end
    end

    assign div_req.start   = (r_state == S_DIV);
    assign div_req.divisor = r_cnt;

    csta_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TDEPTH)
    ) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    csta_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HDEPTH)
    ) u_halo_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (i_value),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    csta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_sum),
        .o_rsp      (div_rsp)
    );

    assign o_result_valid = r_valid;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_average      = r_avg;

    `CSTA_ASSERT_IMPL(a_word_when_idle, i_clk, i_rst_n, o_result_valid, !busy, "word while busy")
    `CSTA_ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, div_rsp.done, r_state == S_WAIT,
                      "divider done outside wait")
    `CSTA_ASSERT_NEXT(a_div_not_instant, i_clk, i_rst_n, div_req.start, !div_rsp.done,
                      "divider done right after start")
    `CSTA_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, r_state == S_DIV,
                      (r_cnt != '0) && (r_cnt <= CNT_W'(1 + 4 * MAX_RADIUS)),
                      "stencil count out of range")

endmodule

>>> bench/tb_top.sv
`default_nettype none

module tb_top
    import csta_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE      = 64;
    localparam int RAD_MAX   = 2;
    localparam int ACC_W     = DATA_W + 4;
    localparam int ITEMS     = 1550;
    localparam int N_PHASES  = 15;
    localparam int PER_PHASE = ITEMS / (N_PHASES - 3);
    localparam int DRAIN     = 40;
    localparam int LIMIT     = 1000000;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef struct {
        t_cmd              cmd;
        logic [1:0]        side;
        logic              depth;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } t_cmd_word;

    typedef struct {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DATA_W-1:0] average;
    } t_avg_word;

    // one stencil read: tile cell (row, col) or halo element (side, depth, col)
    typedef struct {
        bit          halo;
        logic [1:0]  side;
        int unsigned depth;
        int unsigned row;
        int unsigned col;
    } t_tap;
    typedef t_tap t_tap_q[$];

    typedef struct {
        logic [1:0]       radius;
        logic [DIM_W-1:0] dim;
        bit               top;
        bit               bottom;
        bit               left;
        bit               right;
    } t_grid_cfg;

    localparam t_grid_cfg CFG_RESET = '{2'd1, 7'd64, 1'b0, 1'b0, 1'b0, 1'b0};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [1:0]        i_cmd       = '0;
    logic [1:0]        i_side      = '0;
    logic              i_depth     = 1'b0;
    logic [POS_W-1:0]  i_row       = '0;
    logic [POS_W-1:0]  i_col       = '0;
    logic [DATA_W-1:0] i_value     = '0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              o_result_valid;
    logic [POS_W-1:0]  o_out_row;
    logic [POS_W-1:0]  o_out_col;
    logic [DATA_W-1:0] o_average;

    cross_stencil_tile_average u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_side         (i_side),
        .i_depth        (i_depth),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_value        (i_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_average      (o_average)
    );

    always #5ns i_clk = ~i_clk;

    t_cmd_word   cmd_q[$];
    t_avg_word   exp_avg_q[$];
    int unsigned n_pushed   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_err      = 0;
    int unsigned cycle_cnt  = 0;

    // tile model, updated on accepted words
    logic [DATA_W-1:0] mdl_tile [2][TILE][TILE];
    logic [DATA_W-1:0] mdl_halo [4][RAD_MAX][TILE];
    logic              mdl_bank = 1'b0;
    t_grid_cfg         mdl_cfg  = CFG_RESET;

    // written-entry map, tracked as words are queued
    bit        wr_tile [2][TILE][TILE];
    bit        wr_halo [4][RAD_MAX][TILE];
    bit        gen_bank = 1'b0;
    t_grid_cfg gen_cfg  = CFG_RESET;

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > TILE) return TILE;
        return d;
    endfunction

    function automatic t_tap_q stencil_taps(t_grid_cfg g, int unsigned r, int unsigned c);
        t_tap_q      q;
        int unsigned n;
        int unsigned rad;
        int unsigned k;
        int unsigned t;
        n   = eff_dim(g.dim);
        rad = (g.radius == 0) ? 1 : (g.radius > RAD_MAX) ? RAD_MAX : g.radius;
        q.push_back('{1'b0, SIDE_TOP, 0, r, c});
        for (k = 0; k < rad && r + 1 + k < n; k++) q.push_back('{1'b0, SIDE_TOP, 0, r + 1 + k, c});
        if (g.bottom) for (t = 0; k < rad; k++, t++) q.push_back('{1'b1, SIDE_BOTTOM, t, 0, c});
        for (k = 0; k < rad && k < r; k++) q.push_back('{1'b0, SIDE_TOP, 0, r - 1 - k, c});
        if (g.top) for (t = 0; k < rad; k++, t++) q.push_back('{1'b1, SIDE_TOP, t, 0, c});
        for (k = 0; k < rad && c + 1 + k < n; k++) q.push_back('{1'b0, SIDE_TOP, 0, r, c + 1 + k});
        if (g.right) for (t = 0; k < rad; k++, t++) q.push_back('{1'b1, SIDE_RIGHT, t, 0, r});
        for (k = 0; k < rad && k < c; k++) q.push_back('{1'b0, SIDE_TOP, 0, r, c - 1 - k});
        if (g.left) for (t = 0; k < rad; k++, t++) q.push_back('{1'b1, SIDE_LEFT, t, 0, r});
        return q;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return ALL_ONES;
            1: return '0;
            2: return DATA_W'($urandom_range(0, 1 << 20));
            default: return raw[DATA_W-1:0];
        endcase
    endfunction

    function automatic int unsigned pick_pos(int unsigned n);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    task automatic push_word(t_cmd cmd, logic [1:0] side, logic depth, int unsigned row,
                             int unsigned col, logic [DATA_W-1:0] value);
        t_cmd_word   w;
        int unsigned n;
        n = eff_dim(gen_cfg.dim);
        w = '{cmd, side, depth, POS_W'(row), POS_W'(col), value};
        cmd_q.push_back(w);
        n_pushed++;
        case (cmd)
            CMD_WR_TILE: if (row < n && col < n) wr_tile[gen_bank][row][col] = 1'b1;
            CMD_WR_HALO: if (col < n) wr_halo[side][depth][col] = 1'b1;
            CMD_COMPUTE: if (row < n && col < n) wr_tile[!gen_bank][row][col] = 1'b1;
            CMD_COMMIT:  gen_bank = !gen_bank;
            default: ;
        endcase
    endtask

    // loads every entry the stencil would read that was never written, then computes
    task automatic push_compute(int unsigned row, int unsigned col, bit ones);
        t_tap_q      taps;
        int unsigned n;
        n = eff_dim(gen_cfg.dim);
        if (row < n && col < n) begin
            taps = stencil_taps(gen_cfg, row, col);
            foreach (taps[i]) begin
                if (taps[i].halo) begin
                    if (!wr_halo[taps[i].side][taps[i].depth][taps[i].col])
                        push_word(CMD_WR_HALO, taps[i].side, taps[i].depth[0],
                                  $urandom_range(0, 63), taps[i].col,
                                  ones ? ALL_ONES : rand_value());
                end else if (!wr_tile[gen_bank][taps[i].row][taps[i].col]) begin
                    push_word(CMD_WR_TILE, 2'($urandom), 1'($urandom), taps[i].row,
                              taps[i].col, ones ? ALL_ONES : rand_value());
                end
            end
        end
        push_word(CMD_COMPUTE, 2'($urandom), 1'($urandom), row, col, rand_value());
    endtask

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk); while (n_accepted != n_pushed || exp_avg_q.size() != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // command driver
    t_cmd_word drv_word;
    int        hold_off = 0;
    bit        no_gaps  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            hold_off <= 0;
        end else if (!(start && busy)) begin
            if (hold_off != 0) begin
                start    <= 1'b0;
                hold_off <= hold_off - 1;
            end else if (cmd_q.size() != 0) begin
                drv_word = cmd_q.pop_front();
                i_cmd   <= drv_word.cmd;
                i_side  <= drv_word.side;
                i_depth <= drv_word.depth;
                i_row   <= drv_word.row;
                i_col   <= drv_word.col;
                i_value <= drv_word.value;
                start   <= 1'b1;
                if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
                hold_off <= no_gaps ? 0 : $urandom_range(0, 19);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and tile model
    always @(posedge i_clk) begin : mon
        t_avg_word         e;
        t_tap_q            taps;
        logic [ACC_W-1:0]  sum;
        logic [DATA_W-1:0] avg;
        int unsigned       n;
        bit                bad;
        if (!i_rst_n) begin
            mdl_bank = 1'b0;
            mdl_cfg  = CFG_RESET;
        end else begin
            if (o_result_valid) begin
                if (exp_avg_q.size() == 0) begin
                    n_err++;
                    $display("%0t: expected no word, got row %0d col %0d avg %h", $time,
                             o_out_row, o_out_col, o_average);
                end else begin
                    e   = exp_avg_q.pop_front();
                    bad = (o_out_row !== e.row);
                    bad |= (o_out_col !== e.col);
                    bad |= (o_average !== e.average);
                    if (bad) begin
                        n_err++;
                        $display("%0t: expected row %0d col %0d avg %h, got %0d %0d %h",
                                 $time, e.row, e.col, e.average,
                                 o_out_row, o_out_col, o_average);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RADIUS:     mdl_cfg.radius = i_cfg_data[1:0];
                    REG_TILE_DIM:   mdl_cfg.dim    = i_cfg_data;
                    REG_HAS_TOP:    mdl_cfg.top    = i_cfg_data[0];
                    REG_HAS_BOTTOM: mdl_cfg.bottom = i_cfg_data[0];
                    REG_HAS_LEFT:   mdl_cfg.left   = i_cfg_data[0];
                    REG_HAS_RIGHT:  mdl_cfg.right  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                n_accepted++;
                n = eff_dim(mdl_cfg.dim);
                case (t_cmd'(i_cmd))
                    CMD_WR_TILE:
                        if (i_row < n && i_col < n)
                            mdl_tile[mdl_bank][i_row][i_col] = i_value;
                    CMD_WR_HALO: if (i_col < n) mdl_halo[i_side][i_depth][i_col] = i_value;
                    CMD_COMMIT:  mdl_bank = !mdl_bank;
                    CMD_COMPUTE: begin
                        if (i_row < n && i_col < n) begin
                            taps = stencil_taps(mdl_cfg, i_row, i_col);
                            sum  = '0;
                            foreach (taps[i])
                                sum += taps[i].halo ?
                                       mdl_halo[taps[i].side][taps[i].depth][taps[i].col] :
                                       mdl_tile[mdl_bank][taps[i].row][taps[i].col];
                            avg = DATA_W'(sum / taps.size());
                            mdl_tile[!mdl_bank][i_row][i_col] = avg;
                            exp_avg_q.push_back('{i_row, i_col, avg});
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stim
        t_grid_cfg   g;
        int unsigned n;
        int unsigned base;
        int unsigned sel;
        t_cmd        nc;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_quiet();
            case (ph)
                0: g = '{2'd2, 7'd64, 1'b1, 1'b1, 1'b1, 1'b1};
                1: g = '{2'd0, 7'd0, 1'b1, 1'b0, 1'b0, 1'b0};
                2: g = '{2'd3, 7'd127, 1'b0, 1'b0, 1'b1, 1'b1};
                default: begin
                    g.radius = 2'($urandom);
                    case ($urandom_range(0, 9))
                        0: g.dim = 7'd0;
                        1: g.dim = 7'($urandom_range(65, 127));
                        2: g.dim = 7'd64;
                        3: g.dim = 7'($urandom_range(9, 63));
                        default: g.dim = 7'($urandom_range(1, 8));
                    endcase
                    g.top    = 1'($urandom);
                    g.bottom = 1'($urandom);
                    g.left   = 1'($urandom);
                    g.right  = 1'($urandom);
                end
            endcase
            write_cfg(REG_RADIUS, {5'($urandom), g.radius});
            write_cfg(REG_TILE_DIM, g.dim);
            write_cfg(REG_HAS_TOP, {6'($urandom), g.top});
            write_cfg(REG_HAS_BOTTOM, {6'($urandom), g.bottom});
            write_cfg(REG_HAS_LEFT, {6'($urandom), g.left});
            write_cfg(REG_HAS_RIGHT, {6'($urandom), g.right});
            i_cfg_valid <= 1'b0;
            gen_cfg = g;
            n = eff_dim(g.dim);
            case (ph)
                0: begin
                    push_word(CMD_WR_TILE, SIDE_RIGHT, 1'b1, 0, 0, ALL_ONES);
                    push_word(CMD_WR_TILE, SIDE_TOP, 1'b0, 63, 63, '0);
                    push_compute(0, 0, 1'b0);
                    push_compute(63, 63, 1'b0);
                    // nine all-ones taps: widest sum
                    push_compute(40, 40, 1'b1);
                    push_compute(63, 0, 1'b0);
                    push_compute(0, 63, 1'b0);
                    push_word(CMD_WR_HALO, SIDE_BOTTOM, 1'b1, 63, 63, ALL_ONES);
                    push_compute(63, 63, 1'b0);
                    push_word(CMD_COMMIT, SIDE_LEFT, 1'b1, 63, 63, ALL_ONES);
                    push_compute(0, 0, 1'b0);
                    push_compute(40, 40, 1'b0);
                    push_word(CMD_COMMIT, SIDE_TOP, 1'b0, 0, 0, '0);
                    push_compute(40, 40, 1'b0);
                end
                1: begin
                    // radius 0 and tile size 0 both act as 1; left halo stored while disabled
                    push_word(CMD_WR_TILE, SIDE_TOP, 1'b0, 5, 0, rand_value());
                    push_word(CMD_WR_TILE, SIDE_TOP, 1'b0, 0, 5, rand_value());
                    push_word(CMD_WR_HALO, SIDE_LEFT, 1'b0, 9, 0, rand_value());
                    push_word(CMD_WR_HALO, SIDE_LEFT, 1'b1, 9, 0, rand_value());
                    push_word(CMD_WR_HALO, SIDE_RIGHT, 1'b0, 0, 1, rand_value());
                    push_compute(0, 1, 1'b0);
                    push_compute(1, 0, 1'b0);
                    push_compute(0, 0, 1'b0);
                    push_word(CMD_COMMIT, SIDE_BOTTOM, 1'b0, 1, 1, rand_value());
                    push_compute(0, 0, 1'b0);
                end
                2: begin
                    push_compute(0, 0, 1'b0);
                    push_compute(63, 63, 1'b0);
                end
                default: begin
                    base = n_pushed;
                    while (n_pushed - base < PER_PHASE) begin
                        sel = $urandom_range(0, 99);
                        if (sel < 45)
                            push_compute(pick_pos(n), pick_pos(n), 1'b0);
                        else if (sel < 63)
                            push_word(CMD_WR_TILE, 2'($urandom), 1'($urandom), pick_pos(n),
                                      pick_pos(n), rand_value());
                        else if (sel < 78)
                            push_word(CMD_WR_HALO, 2'($urandom), 1'($urandom),
                                      $urandom_range(0, 63), pick_pos(n), rand_value());
                        else if (sel < 84)
                            push_word(CMD_COMMIT, 2'($urandom), 1'($urandom),
                                      $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
                        else begin
                            nc = t_cmd'($urandom_range(0, 3));
                            if (nc == CMD_COMPUTE)
                                push_compute($urandom_range(0, 63), $urandom_range(0, 63), 1'b0);
                            else
                                push_word(nc, 2'($urandom), 1'($urandom), $urandom_range(0, 63),
                                          $urandom_range(0, 63), rand_value());
                        end
                    end
                end
            endcase
        end
        wait_quiet();
        if (n_err == 0 && exp_avg_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/csta_pkg.sv
rtl/csta_ram.sv
rtl/csta_div.sv
rtl/cross_stencil_tile_average.sv
bench/tb_top.sv
